>>> src/bpfa_pkg.sv
// Package: types and constants shared by the bitmap page frame allocator.
`timescale 1ns / 1ps

package bpfa_pkg;

  localparam int unsigned PoolMb     = 4;
  localparam int unsigned WordsPerMb = 8;
  localparam int unsigned NumWords   = PoolMb * WordsPerMb;
  localparam int unsigned WordIdxW   = $clog2(NumWords);
  localparam int unsigned WordBits   = 32;
  localparam int unsigned BitIdxW    = 5;
  localparam int unsigned PageShift  = 12;
  localparam int unsigned WordShift  = 17;
  localparam int unsigned MbShift    = 20;
  localparam int unsigned BaseMbW    = 12;
  localparam logic [31:0] PoolBytes  = 32'(PoolMb) << MbShift;

  typedef enum logic {
    OpAlloc = 1'b0,
    OpFree  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StFull     = 2'd1,
    StNotAlloc = 2'd2,
    StOutside  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SScan,
    SFreeChk,
    SFreeUpd,
    SDone
  } state_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic [31:0] frame_address;
    status_e     status;
  } rsp_t;

endpackage

>>> src/bitmap_page_frame_allocator.sv
// Top level: bitmap page frame allocator with the bitmap held in a synchronous RAM.
//
// Usage: requests arrive on in_valid_i/in_ready_o with in_req_i (opcode, address);
// one response per request leaves on out_valid_o/out_ready_i with out_rsp_o
// (frame_address, status). base_mb is written through cfg_we_i/cfg_wdata_i; the user
// must do so only while idle, as the block does not enforce it. One request is in
// work at a time; in_ready_o is high while no request is in work. Allocate reads the
// bitmap words one per cycle from word 0 through the single RAM read port and stops
// at the first word that is not full, or reports full after the last word. Free
// reads and rewrites one word, and skips the RAM when the address lies outside the
// pool. Sustained rate is therefore set by the word scan of the RAM port.
// The response sits in an output register: a new request is taken while it waits,
// and a finished result waits in the done state until the output register frees.
// Reset clears the per-word valid bits, so every frame reads as free at once, with
// no clearing pass; base_mb resets to 0.
`timescale 1ns / 1ps

module bitmap_page_frame_allocator (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  bpfa_pkg::req_t        in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output bpfa_pkg::rsp_t        out_rsp_o,
  input  logic                  cfg_we_i,
  input  logic [11:0]           cfg_wdata_i
);

  localparam int unsigned W = bpfa_pkg::WordIdxW;
  localparam logic [W-1:0] LastWord = W'(bpfa_pkg::NumWords - 1);

  bpfa_pkg::state_e state_q, state_d;
  bpfa_pkg::req_t   req_q, req_d;
  bpfa_pkg::rsp_t   res_q, res_d;
  bpfa_pkg::rsp_t   out_q;
  logic             out_valid_q;
  logic             out_load;
  logic [11:0]      base_mb_q;
  logic [W-1:0]     idx_q, idx_d;
  logic             rd_pend_q, rd_pend_d;
  logic [W-1:0]     rd_idx_q;
  logic             rd_vld_q;

  logic [31:0]      mem_q [bpfa_pkg::NumWords];
  logic [31:0]      mem_rdata_q;
  logic [bpfa_pkg::NumWords-1:0] word_vld_q;
  logic             mem_re, mem_we;
  logic [W-1:0]     mem_raddr, mem_waddr;
  logic [31:0]      mem_wdata;

  logic [31:0]      rd_word;
  logic [31:0]      zero_oh;
  logic [4:0]       zero_bit;
  logic [31:0]      base_addr;
  logic [31:0]      alloc_addr;
  logic [31:0]      page;
  logic [32:0]      off;
  logic             outside;
  logic [W-1:0]     free_word;
  logic [4:0]       free_bit;
  logic [31:0]      free_oh;

  assign rd_word   = rd_vld_q ? mem_rdata_q : '0;
  assign zero_oh   = ~rd_word & (rd_word + 32'd1);
  assign base_addr = {base_mb_q, 20'd0};
  assign alloc_addr = base_addr + 32'({rd_idx_q, zero_bit, 12'd0});
  assign page      = req_q.address & 32'hFFFF_F000;
  assign off       = {1'b0, page} - {1'b0, base_addr};
  assign outside   = off[32] || (off[31:0] >= bpfa_pkg::PoolBytes);
  assign free_word = off[bpfa_pkg::WordShift +: W];
  assign free_bit  = off[bpfa_pkg::PageShift +: bpfa_pkg::BitIdxW];
  assign free_oh   = 32'd1 << free_bit;

  always_comb begin
    zero_bit = '0;
    for (int i = 0; i < 32; i++) begin
      if (zero_oh[i]) begin
        zero_bit = zero_bit | 5'(i);
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    res_d     = res_q;
    idx_d     = idx_q;
    rd_pend_d = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = idx_q;
    mem_we    = 1'b0;
    mem_waddr = rd_idx_q;
    mem_wdata = rd_word;
    out_load  = 1'b0;
    unique case (state_q)
      bpfa_pkg::SIdle: begin
        if (in_valid_i) begin
          req_d   = in_req_i;
          idx_d   = '0;
          state_d = (in_req_i.opcode == bpfa_pkg::OpAlloc) ? bpfa_pkg::SScan
                                                            : bpfa_pkg::SFreeChk;
        end
      end
      bpfa_pkg::SScan: begin
        mem_re    = 1'b1;
        mem_raddr = idx_q;
        rd_pend_d = 1'b1;
        idx_d     = (idx_q == LastWord) ? '0 : idx_q + W'(1);
        if (rd_pend_q) begin
          if (rd_word != 32'hFFFF_FFFF) begin
            mem_we    = 1'b1;
            mem_wdata = rd_word | zero_oh;
            res_d     = '{frame_address: alloc_addr, status: bpfa_pkg::StOk};
            state_d   = bpfa_pkg::SDone;
          end else if (rd_idx_q == LastWord) begin
            res_d   = '{frame_address: 32'd0, status: bpfa_pkg::StFull};
            state_d = bpfa_pkg::SDone;
          end
        end
      end
      bpfa_pkg::SFreeChk: begin
        if (outside) begin
          res_d   = '{frame_address: 32'd0, status: bpfa_pkg::StOutside};
          state_d = bpfa_pkg::SDone;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = free_word;
          state_d   = bpfa_pkg::SFreeUpd;
        end
      end
      bpfa_pkg::SFreeUpd: begin
        if ((rd_word & free_oh) == 32'd0) begin
          res_d = '{frame_address: 32'd0, status: bpfa_pkg::StNotAlloc};
        end else begin
          mem_we    = 1'b1;
          mem_wdata = rd_word & ~free_oh;
          res_d     = '{frame_address: 32'd0, status: bpfa_pkg::StOk};
        end
        state_d = bpfa_pkg::SDone;
      end
      bpfa_pkg::SDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = bpfa_pkg::SIdle;
        end
      end
      default: begin
        state_d = bpfa_pkg::SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpfa_pkg::SIdle;
      out_valid_q <= 1'b0;
      base_mb_q   <= '0;
      rd_pend_q   <= 1'b0;
      idx_q       <= '0;
      word_vld_q  <= '0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= rd_pend_d;
      idx_q     <= idx_d;
      if (cfg_we_i) begin
        base_mb_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (mem_we) begin
        word_vld_q[mem_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
      rd_idx_q    <= mem_raddr;
      rd_vld_q    <= word_vld_q[mem_raddr];
    end
  end

  assign in_ready_o  = (state_q == bpfa_pkg::SIdle);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
